### rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator.
// Holds the transaction payload types, command, status and register codes,
// and the result type of the shared divider. No dependencies.
package fbpa_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BYTES_W    = 25;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned ALIGN_W    = 3;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MAX_BLOCKS_DEF = 256;

  // Counter saturation limits.
  localparam logic [BYTES_W-1:0] USED_MAX  = '1;
  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REBUILD = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT_LOG2 = 2'd3;

  // Configuration reset values.
  localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS   = '0;
  localparam logic [BYTES_W-1:0] RST_POOL_BYTES     = '0;
  localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE     = 17'd8;
  localparam logic [ALIGN_W-1:0] RST_ALIGNMENT_LOG2 = 3'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] request_alignment_log2;
    logic [ADDR_W-1:0]  free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
    logic [BYTES_W-1:0]  used_bytes;
    logic [CNT_W-1:0]    allocation_count;
  } out_item_t;

  // Result of the shared divider: a one-cycle done pulse with the answer.
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quot;
    logic [SIZE_W-1:0] rem;
  } div_res_t;

endpackage

### rtl/fbpa_div.sv
// Shared restoring divider of the fixed block pool allocator.
// Produces one quotient bit per cycle; depends on fbpa_pkg.
module fbpa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output fbpa_pkg::div_res_t        res
);
  import fbpa_pkg::*;

  localparam int unsigned STEPS = ADDR_W;
  localparam int unsigned STEP_W = $clog2(STEPS + 1);

  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              fits;

  // One restoring step: bring in the next dividend bit and try a subtract.
  assign trial = {rem_r, quo_r[ADDR_W-1]};
  assign fits  = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt = STEP_W'(STEPS);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == STEP_W'(1));
      quo_nxt  = {quo_r[ADDR_W-2:0], fits};
      rem_nxt  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

### rtl/fixed_block_pool_allocator.sv
// Fixed block pool allocator, top level; depends on fbpa_pkg and fbpa_div.
// Path of a transaction: an allocate goes through a write-back state to the result
// state (straight there on a size or alignment mismatch, an empty pool or the unused command).
// One transaction is in work at a time; free and rebuild time is set by the
// 32-step shared divider, rebuild also by the one-link-per-cycle RAM walk.
// Synchronous active-low reset: empty pool, zero counters, registers at reset values.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fbpa_pkg::in_item_t             in_data,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output fbpa_pkg::out_item_t            out_data,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fbpa_pkg::*;

  // A link holds a block index or the "none" marker, which equals MAX_BLOCKS.
  localparam int unsigned IDXW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned PRODW = IDXW + SIZE_W;
  localparam logic [IDXW-1:0] LINK_NONE = IDXW'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_WB,
    S_FREE_DIV,
    S_RB_DIV,
    S_RB_WALK,
    S_DONE
  } state_t;

  // Configuration registers.
  logic [ADDR_W-1:0]  cfg_base_r;
  logic [BYTES_W-1:0] cfg_pool_r;
  logic [SIZE_W-1:0]  cfg_bsize_r;
  logic [ALIGN_W-1:0] cfg_align_r;

  // Control and pool state.
  state_t              state_r, state_nxt;
  logic [IDXW-1:0]     free_head_r, free_head_nxt;
  logic [IDXW-1:0]     block_count_r, block_count_nxt;
  logic [ADDR_W-1:0]   first_blk_r, first_blk_nxt;
  logic [BYTES_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [IDXW-1:0]     walk_idx_r, walk_idx_nxt;
  logic [PRODW-1:0]    prod_r, prod_nxt;
  logic [ADDR_W-1:0]   granted_r, granted_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Free-list link RAM: one write port, one registered read port.
  logic [IDXW-1:0] link_mem [MAX_BLOCKS];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [IDXW-1:0] mem_wdata;
  logic            mem_re;
  logic [IDXW-1:0] mem_rdata_r;

  // Shared divider.
  logic              div_start;
  logic [ADDR_W-1:0] div_dividend;
  div_res_t          div_res;

  // Alignment adjustment: the distance from the base up to the next boundary.
  logic [7:0]        align_mask;
  logic [7:0]        adj;
  logic              in_accept;
  logic              out_free;
  logic              free_bad;
  logic              rb_valid;
  logic [IDXW-1:0]   rb_count;
  logic [IDXW-1:0]   walk_inc;
  logic [BYTES_W:0]  used_sum;

  assign align_mask = (8'd1 << cfg_align_r) - 8'd1;
  assign adj        = (8'd0 - cfg_base_r[7:0]) & align_mask;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  // The output register can take a new result when it is empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;

  // The user must write configuration only while no transaction is in work; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r  <= RST_BASE_ADDRESS;
      cfg_pool_r  <= RST_POOL_BYTES;
      cfg_bsize_r <= RST_BLOCK_SIZE;
      cfg_align_r <= RST_ALIGNMENT_LOG2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_ADDRESS:   cfg_base_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_POOL_BYTES:     cfg_pool_r  <= cfg_wdata[BYTES_W-1:0];
        CFG_BLOCK_SIZE:     cfg_bsize_r <= cfg_wdata[SIZE_W-1:0];
        CFG_ALIGNMENT_LOG2: cfg_align_r <= cfg_wdata[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // The divider serves both the free path (offset / block size) and the
  // rebuild path ((pool bytes - adjustment) / block size).
  always_comb begin
    div_start    = in_accept &&
                   (in_data.command == CMD_FREE || in_data.command == CMD_REBUILD);
    div_dividend = (in_data.command == CMD_FREE) ?
                   (in_data.free_address - first_blk_r) :
                   32'(cfg_pool_r - BYTES_W'(adj));
  end

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cfg_bsize_r),
    .res      (div_res)
  );

  // A freed address is bad when the block size is zero, when the offset is
  // not a whole number of blocks, or when it points past the last block.
  assign free_bad = (cfg_bsize_r == '0) || (div_res.rem != '0) ||
                    (div_res.quot >= 32'(block_count_r));

  // A rebuild with a zero block size or a pool smaller than the adjustment
  // leaves an empty pool; otherwise the count is capped at MAX_BLOCKS.
  assign rb_valid = (cfg_bsize_r != '0) && (cfg_pool_r >= BYTES_W'(adj));
  assign rb_count = !rb_valid ? '0 :
                    (div_res.quot > 32'(MAX_BLOCKS)) ? LINK_NONE :
                    div_res.quot[IDXW-1:0];

  assign walk_inc = walk_idx_r + 1'b1;
  assign used_sum = {1'b0, used_r} + (BYTES_W+1)'(cfg_bsize_r);

  always_comb begin
    state_nxt       = state_r;
    free_head_nxt   = free_head_r;
    block_count_nxt = block_count_r;
    first_blk_nxt   = first_blk_r;
    used_nxt        = used_r;
    live_nxt        = live_r;
    walk_idx_nxt    = walk_idx_r;
    prod_nxt        = prod_r;
    granted_nxt     = granted_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    mem_we          = 1'b0;
    mem_waddr       = walk_idx_r[AW-1:0];
    mem_wdata       = (walk_inc < block_count_r) ? walk_inc : LINK_NONE;
    mem_re          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          granted_nxt = '0;
          status_nxt  = ST_OK;
          case (in_data.command)
            CMD_ALLOC: begin
              // The shape check (size and alignment) comes ahead of the empty check.
              if (in_data.request_size != cfg_bsize_r ||
                  in_data.request_alignment_log2 != cfg_align_r) begin
                status_nxt = ST_MISMATCH;
                state_nxt  = S_DONE;
              end else if (free_head_r == LINK_NONE || free_head_r >= block_count_r) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                // Read the head's link and form the block offset together.
                mem_re    = 1'b1;
                prod_nxt  = PRODW'(free_head_r) * PRODW'(cfg_bsize_r);
                state_nxt = S_ALLOC_WB;
              end
            end
            CMD_FREE:    state_nxt = S_FREE_DIV;
            CMD_REBUILD: state_nxt = S_RB_DIV;
            default:     state_nxt = S_DONE;
          endcase
        end
      end

      S_ALLOC_WB: begin
        granted_nxt   = first_blk_r + 32'(prod_r);
        free_head_nxt = mem_rdata_r;
        used_nxt      = used_sum[BYTES_W] ? USED_MAX : used_sum[BYTES_W-1:0];
        live_nxt      = (live_r < COUNT_MAX) ? live_r + 1'b1 : live_r;
        state_nxt     = S_DONE;
      end

      S_FREE_DIV: begin
        if (div_res.done) begin
          if (free_bad) begin
            status_nxt = ST_BAD_FREE;
          end else begin
            // Push the block on the front of the free list.
            mem_we        = 1'b1;
            mem_waddr     = div_res.quot[AW-1:0];
            mem_wdata     = free_head_r;
            free_head_nxt = div_res.quot[IDXW-1:0];
            used_nxt      = (used_r > BYTES_W'(cfg_bsize_r)) ?
                            used_r - BYTES_W'(cfg_bsize_r) : '0;
            live_nxt      = (live_r != '0) ? live_r - 1'b1 : live_r;
          end
          state_nxt = S_DONE;
        end
      end

      S_RB_DIV: begin
        if (div_res.done) begin
          first_blk_nxt   = cfg_base_r + 32'(adj);
          block_count_nxt = rb_count;
          free_head_nxt   = (rb_count != '0) ? '0 : LINK_NONE;
          used_nxt        = '0;
          live_nxt        = '0;
          walk_idx_nxt    = '0;
          state_nxt       = (rb_count != '0) ? S_RB_WALK : S_DONE;
        end
      end

      S_RB_WALK: begin
        // Chain the blocks in address order, one link per cycle.
        mem_we       = 1'b1;
        walk_idx_nxt = walk_inc;
        if (walk_inc >= block_count_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{granted_address:  granted_r,
                            status:           status_r,
                            used_bytes:       used_r,
                            allocation_count: live_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      free_head_r   <= LINK_NONE;
      block_count_r <= '0;
      first_blk_r   <= '0;
      used_r        <= '0;
      live_r        <= '0;
      walk_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      free_head_r   <= free_head_nxt;
      block_count_r <= block_count_nxt;
      first_blk_r   <= first_blk_nxt;
      used_r        <= used_nxt;
      live_r        <= live_nxt;
      walk_idx_r    <= walk_idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    prod_r     <= prod_nxt;
    granted_r  <= granted_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Link RAM; its contents are undefined until a rebuild or a free writes them.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= link_mem[free_head_r[AW-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The free-list head is either empty or a block of the current pool.
  a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r != LINK_NONE) |-> (free_head_r < block_count_r))
    else $error("free-list head lies outside the pool");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    block_count_r <= LINK_NONE)
    else $error("block count exceeds the pool capacity");

  // The divider finishes only while a free or a rebuild waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_FREE_DIV || state_r == S_RB_DIV))
    else $error("divider finished outside a free or rebuild");

  a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_FREE_DIV || state_r == S_RB_WALK))
    else $error("link RAM written outside a free or rebuild walk");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RB_WALK) |-> (walk_idx_r < block_count_r))
    else $error("rebuild walk ran past the last block");

  // An accepted allocate goes from its write-back state straight on to the result state.
  a_alloc_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC_WB) |=> (state_r == S_DONE))
    else $error("allocate did not reach the result stage");

endmodule

### sim/fbpa_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the fixed block pool allocator: it follows the register
// writes and both transaction channels, predicts every result and compares it.
// Depends on fbpa_pkg for the payload types and the command and status codes.
module fbpa_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  fbpa_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  fbpa_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              results_outstanding,
  output int                              mismatch_count
);
  import fbpa_pkg::*;

  localparam int unsigned NUM_SLOTS = MAX_BLOCKS_DEF;
  localparam logic [CNT_W-1:0] NO_LINK = CNT_W'(NUM_SLOTS);

  // Register copies.
  logic [ADDR_W-1:0]  base_addr;
  logic [BYTES_W-1:0] region_bytes;
  logic [SIZE_W-1:0]  blk_size;
  logic [ALIGN_W-1:0] align_log2;

  // Pool state.
  logic [CNT_W-1:0]   next_free [NUM_SLOTS];
  logic [CNT_W-1:0]   free_head;
  logic [ADDR_W-1:0]  pool_start;
  logic [CNT_W-1:0]   block_total;
  logic [BYTES_W-1:0] bytes_in_use;
  logic [CNT_W-1:0]   live_count;

  out_item_t pending_results [$];

  // Align the base, size the pool and chain every block in address order.
  task automatic rebuild_free_list();
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] slack;
    int unsigned count;
    mask = (32'd1 << align_log2) - 32'd1;
    slack = (mask + 32'd1 - (base_addr & mask)) & mask;
    pool_start = base_addr + slack;
    count = 0;
    if (blk_size != '0 && ADDR_W'(region_bytes) >= slack)
      count = (ADDR_W'(region_bytes) - slack) / ADDR_W'(blk_size);
    if (count > NUM_SLOTS)
      count = NUM_SLOTS;
    block_total = CNT_W'(count);
    for (int unsigned i = 0; i < count; i++)
      next_free[i] = (i + 1 < count) ? CNT_W'(i + 1) : NO_LINK;
    free_head = (count > 0) ? '0 : NO_LINK;
    bytes_in_use = '0;
    live_count = '0;
  endtask

  task automatic pool_response(input in_item_t req, output out_item_t rsp);
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] slot;
    logic [31:0] sum;
    rsp = '0;
    rsp.status = ST_OK;
    case (req.command)
      CMD_ALLOC: begin
        if (req.request_size != blk_size || req.request_alignment_log2 != align_log2) begin
          rsp.status = ST_MISMATCH;
        end else if (free_head >= NO_LINK || free_head >= block_total) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.granted_address = pool_start + ADDR_W'(free_head) * ADDR_W'(blk_size);
          free_head = next_free[free_head];
          sum = 32'(bytes_in_use) + 32'(req.request_size);
          bytes_in_use = (sum > 32'(USED_MAX)) ? USED_MAX : sum[BYTES_W-1:0];
          if (live_count != COUNT_MAX)
            live_count = live_count + 1'b1;
        end
      end
      CMD_FREE: begin
        offset = req.free_address - pool_start;
        if (blk_size == '0 || offset % ADDR_W'(blk_size) != '0 ||
            offset / ADDR_W'(blk_size) >= ADDR_W'(block_total)) begin
          rsp.status = ST_BAD_FREE;
        end else begin
          // Double frees are not caught; the block simply goes on the list again.
          slot = offset / ADDR_W'(blk_size);
          next_free[slot] = free_head;
          free_head = CNT_W'(slot);
          bytes_in_use = (bytes_in_use > BYTES_W'(blk_size)) ?
                         bytes_in_use - BYTES_W'(blk_size) : '0;
          if (live_count != '0)
            live_count = live_count - 1'b1;
        end
      end
      CMD_REBUILD: begin
        rebuild_free_list();
      end
      default: begin
      end
    endcase
    rsp.used_bytes = bytes_in_use;
    rsp.allocation_count = live_count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t predicted;
    if (!rst_n) begin
      base_addr = RST_BASE_ADDRESS;
      region_bytes = RST_POOL_BYTES;
      blk_size = RST_BLOCK_SIZE;
      align_log2 = RST_ALIGNMENT_LOG2;
      for (int unsigned i = 0; i < NUM_SLOTS; i++)
        next_free[i] = '0;
      free_head = NO_LINK;
      pool_start = '0;
      block_total = '0;
      bytes_in_use = '0;
      live_count = '0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction arrived with nothing outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("granted_address", want.granted_address, out_data.granted_address);
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("used_bytes", 32'(want.used_bytes), 32'(out_data.used_bytes));
          check_field("allocation_count", 32'(want.allocation_count),
                      32'(out_data.allocation_count));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ADDRESS:   base_addr = cfg_wdata;
          CFG_POOL_BYTES:     region_bytes = cfg_wdata[BYTES_W-1:0];
          CFG_BLOCK_SIZE:     blk_size = cfg_wdata[SIZE_W-1:0];
          CFG_ALIGNMENT_LOG2: align_log2 = cfg_wdata[ALIGN_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        pool_response(in_data, predicted);
        pending_results.push_back(predicted);
      end
    end
    results_outstanding <= pending_results.size();
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, stimulus and the verdict.
// Depends on fbpa_pkg, the fixed_block_pool_allocator RTL and fbpa_checker.
module tb_top;
  import fbpa_pkg::*;

  localparam int CLK_PERIOD    = 8;
  // The slowest correct run (every transaction a full 256-block rebuild with the
  // longest gap and stall) stays well under this.
  localparam int CYCLE_LIMIT   = 4_000_000;
  // Wait after a drain, long enough for a rebuild of 256 blocks plus margin.
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 90;
  localparam int SAT_PHASE     = 4;
  localparam int SAT_ALLOCS    = 530;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [BYTES_W-1:0] POOL_MAX = 25'd16777216;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int results_outstanding;
  int mismatch_count;
  int cycle_count;

  // Idling switches for the two sides; both are cleared for the last phases.
  bit src_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;

  // Register values as last written, so that well-formed allocates can be made.
  logic [ADDR_W-1:0]  cur_base;
  logic [BYTES_W-1:0] cur_pool;
  logic [SIZE_W-1:0]  cur_bsize;
  logic [ALIGN_W-1:0] cur_align;

  // Commands in flight, and the block addresses handed out since the last
  // rebuild. held_addrs are still owned by the testbench; granted_addrs keeps
  // every grant so that stale and double frees can be produced.
  logic [CMD_W-1:0]  issued_cmds [$];
  logic [ADDR_W-1:0] held_addrs [$];
  logic [ADDR_W-1:0] granted_addrs [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  fixed_block_pool_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fbpa_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data            (out_data),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .results_outstanding (results_outstanding),
    .mismatch_count      (mismatch_count)
  );

  // Nothing here changes between a falling edge and the next rising edge, so
  // the handshakes seen at the falling edge are the ones taken at the next
  // rising edge. Tracking them here keeps the address lists settled before the
  // stimulus process looks at them.
  always @(negedge clk) begin : grant_tracker
    logic [CMD_W-1:0] done_cmd;
    if (rst_n && out_valid && !out_stall && issued_cmds.size() > 0) begin
      done_cmd = issued_cmds.pop_front();
      if (done_cmd == CMD_REBUILD) begin
        held_addrs.delete();
        granted_addrs.delete();
      end else if (done_cmd == CMD_ALLOC && out_data.status == ST_OK) begin
        held_addrs.push_back(out_data.granted_address);
        granted_addrs.push_back(out_data.granted_address);
      end
    end
    if (rst_n && in_valid && !in_stall)
      issued_cmds.push_back(in_data.command);
  end

  // The result side stalls in bursts while idling is on.
  initial begin : sink_stall
    forever begin
      @(posedge clk);
      if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL fixed_block_pool_allocator");
    $finish;
  end

  // Offers one transaction and returns at the rising edge that takes it.
  // Valid stays high on return, so back-to-back transactions need only one
  // assignment per edge; a gap lowers valid first.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                       input logic [ALIGN_W-1:0] align, input logic [ADDR_W-1:0] addr);
    in_item_t item;
    item.command = cmd;
    item.request_size = size;
    item.request_alignment_log2 = align;
    item.free_address = addr;
    send_item(item);
  endtask

  // Holds the input side until every outstanding result has come back. The
  // first edge lets the checker count the transaction taken just before.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [ADDR_W-1:0] base, input logic [BYTES_W-1:0] pool,
                              input logic [SIZE_W-1:0] bsize, input logic [ALIGN_W-1:0] align);
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_POOL_BYTES, CFG_DATA_W'(pool));
    write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bsize));
    write_reg(CFG_ALIGNMENT_LOG2, CFG_DATA_W'(align));
    cfg_we <= 1'b0;
    cur_base = base;
    cur_pool = pool;
    cur_bsize = bsize;
    cur_align = align;
  endtask

  function automatic logic [SIZE_W-1:0] random_block_size();
    case ($urandom_range(0, 9))
      0:       return SIZE_W'(8);
      1:       return SIZE_W'(65536);
      2:       return SIZE_W'($urandom_range(8, 65536));
      default: return SIZE_W'($urandom_range(8, 64));
    endcase
  endfunction

  // Most transactions are well-formed: allocates of the configured shape and
  // frees of blocks the testbench holds. The rest is noise: wrong shapes, stray,
  // misaligned and double frees, rebuilds in mid-stream and the unused command.
  task automatic make_random_item(output in_item_t item);
    int pick;
    int k;
    item.command = CMD_ALLOC;
    item.request_size = SIZE_W'($urandom_range(0, 65536));
    item.request_alignment_log2 = ALIGN_W'($urandom_range(0, 7));
    item.free_address = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 80 && held_addrs.size() == 0)) begin
      item.request_size = cur_bsize;
      item.request_alignment_log2 = cur_align;
    end else if (pick < 80) begin
      item.command = CMD_FREE;
      k = $urandom_range(0, held_addrs.size() - 1);
      item.free_address = held_addrs[k];
      held_addrs.delete(k);
    end else if (pick < 86) begin
      // Allocate with a wrong shape; one of the two fields may still match.
      case ($urandom_range(0, 2))
        0: item.request_size = cur_bsize;
        1: item.request_alignment_log2 = cur_align;
        default: begin
        end
      endcase
    end else if (pick < 94) begin
      item.command = CMD_FREE;
      if (granted_addrs.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, granted_addrs.size() - 1);
        item.free_address = granted_addrs[k];
        if ($urandom_range(0, 1) == 0)
          item.free_address = item.free_address + 32'($urandom_range(0, 16)) - 32'd8;
      end
    end else if (pick < 97) begin
      item.command = CMD_REBUILD;
    end else begin
      item.command = CMD_UNUSED;
    end
  endtask

  // One phase of random traffic on a fresh geometry. The early phases take
  // the extremes; odd phases also change block size and alignment halfway
  // through without a rebuild.
  task automatic run_random_phase(input int ph);
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  bsize;
    logic [ALIGN_W-1:0] align;
    longint unsigned    pool;
    int                 blocks;
    in_item_t           item;
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1;
      2:       base = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      default: base = $urandom();
    endcase
    align = ALIGN_W'($urandom_range(0, 7));
    bsize = random_block_size();
    blocks = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(0, 12);
    pool = longint'(blocks) * longint'(bsize) + longint'($urandom_range(0, 200));
    case (ph)
      0: begin
        align = '0;
        bsize = SIZE_W'(8);
        pool = POOL_MAX;
      end
      1: begin
        align = 3'd7;
        bsize = SIZE_W'(65536);
        pool = POOL_MAX;
      end
      2: pool = 0;
      default: begin
      end
    endcase
    if (pool > longint'(POOL_MAX))
      pool = POOL_MAX;
    program_regs(base, BYTES_W'(pool), bsize, align);
    issue(CMD_REBUILD, SIZE_W'($urandom_range(0, 65536)), ALIGN_W'($urandom_range(0, 7)),
          $urandom());
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2 && ph % 2 == 1) begin
        wait_idle();
        program_regs(cur_base, cur_pool, random_block_size(), ALIGN_W'($urandom_range(0, 7)));
      end else if ($urandom_range(0, 39) == 0) begin
        wait_drain();
      end
      make_random_item(item);
      send_item(item);
    end
  endtask

  // A block freed twice in a row links to itself, so the same block can be
  // allocated without end. With 64 KiB blocks this drives both counters into
  // saturation, and the frees after it bring them down again.
  task automatic run_saturation();
    logic [ADDR_W-1:0] blk;
    blk = 32'h8000_0000;
    program_regs(blk, POOL_MAX, SIZE_W'(65536), 3'd7);
    issue(CMD_REBUILD, '0, '0, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);
    issue(CMD_FREE, '0, '0, blk);
    issue(CMD_FREE, '0, '0, blk);
    repeat (SAT_ALLOCS) issue(CMD_ALLOC, cur_bsize, cur_align, $urandom());
    repeat (5) issue(CMD_FREE, SIZE_W'($urandom_range(0, 65536)), '0, blk);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    cur_base = RST_BASE_ADDRESS;
    cur_pool = RST_POOL_BYTES;
    cur_bsize = RST_BLOCK_SIZE;
    cur_align = RST_ALIGNMENT_LOG2;

    // Directed part. Reset values give a pool with no blocks: allocates find
    // it empty unless the shape is wrong, and every free address is bad.
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);
    issue(CMD_ALLOC, SIZE_W'(65536), cur_align, '0);
    issue(CMD_FREE, '0, '0, '0);
    issue(CMD_UNUSED, '1, '1, '1);
    issue(CMD_REBUILD, '0, '0, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);

    // Base just below the top of the address space: aligning it up wraps the
    // first block to address 0, and 55 bytes leave room for three blocks.
    wait_idle();
    program_regs(32'hFFFF_FFF9, 25'd55, 17'd16, 3'd3);
    issue(CMD_REBUILD, '0, '0, '0);
    issue(CMD_ALLOC, cur_bsize, 3'd2, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);
    issue(CMD_FREE, '0, '0, 32'd16);
    issue(CMD_FREE, '0, '0, 32'd17);
    issue(CMD_FREE, '0, '0, 32'd48);
    issue(CMD_FREE, '0, '0, 32'hFFFF_FFF0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);
    // Double free: block 0 goes on the list twice and comes out twice.
    issue(CMD_FREE, '0, '0, '0);
    issue(CMD_FREE, '0, '0, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);

    // A region smaller than the alignment slack yields an empty pool.
    wait_idle();
    program_regs(32'hFFFF_FFF9, 25'd3, 17'd16, 3'd3);
    issue(CMD_REBUILD, '0, '0, '0);
    issue(CMD_ALLOC, cur_bsize, cur_align, '0);

    // Random part; the last two phases run without idling on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      src_idle_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      sink_idle_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (ph == SAT_PHASE)
        run_saturation();
      else
        run_random_phase(ph);
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("PASS fixed_block_pool_allocator");
    end else begin
      $display("FAIL fixed_block_pool_allocator");
    end
    $finish;
  end

endmodule
